// ===== design/cbc_pkg.sv =====
`timescale 1ns / 1ps
// cbc_pkg: shared widths, register map, reset values and the divider request type
// for the color blob centroid block. No dependencies.
package cbc_pkg;

  // Field widths fixed by the interface definition
  localparam int FW_W   = 11;   // frame_width register
  localparam int LIM_W  = 8;    // color components and limits
  localparam int SUM_W  = 30;   // column / row accumulators
  localparam int CNT_W  = 21;   // match counter
  localparam int CTR_W  = 18;   // centroid outputs
  localparam int DATA_W = 32;   // APB data
  localparam int ADDR_W = 4;    // APB byte address

  // Default build parameters
  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_MAX_HEIGHT    = 1024;
  localparam int DEF_FRACTION_BITS = 8;
  localparam int FIFO_DEPTH        = 4;

  // Register reset values
  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH = FW_W'(320);
  localparam logic [LIM_W-1:0] RST_RED_LIMIT   = LIM_W'(75);
  localparam logic [LIM_W-1:0] RST_GREEN_LIMIT = LIM_W'(200);
  localparam logic [LIM_W-1:0] RST_BLUE_LIMIT  = LIM_W'(75);

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] REG_RED_LIMIT   = 2'd1;
  localparam logic [1:0] REG_GREEN_LIMIT = 2'd2;
  localparam logic [1:0] REG_BLUE_LIMIT  = 2'd3;

  // Latched frame totals handed from the accumulator to the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
  } div_req_t;

endpackage

// ===== design/cbc_if.sv =====
`timescale 1ns / 1ps
// cbc_if: valid/ready channel interfaces for pixels in and centroids out.
// Depends on cbc_pkg for field widths.
interface pixel_if;
  import cbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] red;
  logic [LIM_W-1:0] green;
  logic [LIM_W-1:0] blue;
  logic             end_of_frame;

  modport source (output valid, red, green, blue, end_of_frame, input ready);
  modport sink   (input valid, red, green, blue, end_of_frame, output ready);
endinterface

interface centroid_if;
  import cbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CTR_W-1:0] centre_x;
  logic [CTR_W-1:0] centre_y;
  logic [CNT_W-1:0] pixel_count;

  modport source (output valid, centre_x, centre_y, pixel_count, input ready);
  modport sink   (input valid, centre_x, centre_y, pixel_count, output ready);
endinterface

// ===== design/cbc_front.sv =====
`timescale 1ns / 1ps
// cbc_front: accepts pixels, applies the color thresholds and tracks column/row.
// Depends on cbc_pkg and pixel_if; pushes classified entries into cbc_fifo.
module cbc_front #(
  parameter int MAX_WIDTH  = cbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pixel_if.sink                     pix_in,
  input  logic [cbc_pkg::FW_W-1:0]  frame_width_i,
  input  logic [cbc_pkg::LIM_W-1:0] red_limit_i,
  input  logic [cbc_pkg::LIM_W-1:0] green_limit_i,
  input  logic [cbc_pkg::LIM_W-1:0] blue_limit_i,
  input  logic                      full_i,
  output logic                      push_o,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+1:0] entry_o
);
  import cbc_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);
  // compare width covers both the register and MAX_WIDTH itself
  localparam int WW   = (ColW + 1 > FW_W) ? ColW + 1 : FW_W;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [WW-1:0]   fw_ext, w_eff, col_inc;
  logic            match;

  assign pix_in.ready = !full_i;
  assign push_o       = pix_in.valid && !full_i;

  assign match = (pix_in.red < red_limit_i) && (pix_in.green > green_limit_i) &&
                 (pix_in.blue < blue_limit_i);

  assign entry_o = {match, pix_in.end_of_frame, col_q, row_q};

  // zero width acts as one, oversize widths clamp to MAX_WIDTH
  assign fw_ext  = WW'(frame_width_i);
  assign w_eff   = (fw_ext == '0) ? WW'(1) :
                   (fw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw_ext;
  assign col_inc = WW'(col_q) + WW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_in.end_of_frame) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w_eff) begin
      col_d = '0;
      if (row_q != RowW'(MAX_HEIGHT - 1)) row_d = row_q + RowW'(1);
    end else begin
      col_d = col_inc[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== design/cbc_fifo.sv =====
`timescale 1ns / 1ps
// cbc_fifo: small register queue between the classifier and the accumulator.
// Depends on cbc_pkg for the default depth and the shared import convention.
module cbc_fifo #(
  parameter int WIDTH = 22,
  parameter int DEPTH = cbc_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);
  import cbc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(DEPTH))
    else $error("fifo occupancy above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// ===== design/cbc_accum.sv =====
`timescale 1ns / 1ps
// cbc_accum: drains classified pixels, keeps saturating column/row sums and the
// match count, and hands frame totals to cbc_div. Depends on cbc_pkg.
module cbc_accum #(
  parameter int MAX_WIDTH  = cbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+1:0] entry_i,
  output logic                pop_o,
  input  logic                div_ready_i,
  output logic                req_valid_o,
  output cbc_pkg::div_req_t   req_o
);
  import cbc_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);

  logic             match, eof;
  logic [ColW-1:0]  col;
  logic [RowW-1:0]  row;
  logic [SUM_W-1:0] sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W:0]   add_x, add_y;
  logic [CNT_W:0]   add_c;

  assign {match, eof, col, row} = entry_i;

  assign add_x = (SUM_W+1)'(sum_x_q) + (SUM_W+1)'(col);
  assign add_y = (SUM_W+1)'(sum_y_q) + (SUM_W+1)'(row);
  assign add_c = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(1);

  assign sum_x_d = !match ? sum_x_q : (add_x[SUM_W] ? '1 : add_x[SUM_W-1:0]);
  assign sum_y_d = !match ? sum_y_q : (add_y[SUM_W] ? '1 : add_y[SUM_W-1:0]);
  assign cnt_d   = !match ? cnt_q   : (add_c[CNT_W] ? '1 : add_c[CNT_W-1:0]);

  // the frame's last pixel waits until the divider can take the totals
  assign pop_o       = valid_i && (!eof || div_ready_i);
  assign req_valid_o = pop_o && eof && (cnt_d != '0);
  assign req_o       = '{sum_x: sum_x_d, sum_y: sum_y_d, count: cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else if (pop_o) begin
      if (eof) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        cnt_q   <= '0;
      end else begin
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
        cnt_q   <= cnt_d;
      end
    end
  end

endmodule

// ===== design/cbc_div.sv =====
`timescale 1ns / 1ps
// cbc_div: bit-serial restoring divider for both centroid axes, holding the
// result as the output register. Depends on cbc_pkg and centroid_if.
module cbc_div #(
  parameter int FRACTION_BITS = cbc_pkg::DEF_FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  cbc_pkg::div_req_t req_i,
  output logic              ready_o,
  centroid_if.source        cen_out
);
  import cbc_pkg::*;

  localparam int DW   = SUM_W + FRACTION_BITS;
  localparam int StpW = $clog2(DW);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;

  state_e           state_q;
  logic [StpW-1:0]  step_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [DW-1:0]    dq_x_q, dq_y_q;
  logic [CNT_W:0]   trial_x, trial_y, diff_x, diff_y;
  logic             ge_x, ge_y;

  // dq holds the dividend shifting out at the top and quotient bits entering below
  assign trial_x = {rem_x_q, dq_x_q[DW-1]};
  assign trial_y = {rem_y_q, dq_y_q[DW-1]};
  assign diff_x  = trial_x - {1'b0, cnt_q};
  assign diff_y  = trial_y - {1'b0, cnt_q};
  assign ge_x    = trial_x >= {1'b0, cnt_q};
  assign ge_y    = trial_y >= {1'b0, cnt_q};
  assign rem_x_d = ge_x ? diff_x[CNT_W-1:0] : trial_x[CNT_W-1:0];
  assign rem_y_d = ge_y ? diff_y[CNT_W-1:0] : trial_y[CNT_W-1:0];

  assign ready_o             = (state_q == S_IDLE);
  assign cen_out.valid       = (state_q == S_DONE);
  assign cen_out.centre_x    = (|dq_x_q[DW-1:CTR_W]) ? '1 : dq_x_q[CTR_W-1:0];
  assign cen_out.centre_y    = (|dq_y_q[DW-1:CTR_W]) ? '1 : dq_y_q[CTR_W-1:0];
  assign cen_out.pixel_count = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      rem_x_q <= '0;
      rem_y_q <= '0;
      dq_x_q  <= '0;
      dq_y_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            cnt_q   <= req_i.count;
            dq_x_q  <= DW'(req_i.sum_x) << FRACTION_BITS;
            dq_y_q  <= DW'(req_i.sum_y) << FRACTION_BITS;
            rem_x_q <= '0;
            rem_y_q <= '0;
            step_q  <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          rem_x_q <= rem_x_d;
          rem_y_q <= rem_y_d;
          dq_x_q  <= {dq_x_q[DW-2:0], ge_x};
          dq_y_q  <= {dq_y_q[DW-2:0], ge_y};
          step_q  <= step_q + StpW'(1);
          if (step_q == StpW'(DW - 1)) state_q <= S_DONE;
        end
        S_DONE: begin
          if (cen_out.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cen_out.valid |-> cnt_q != '0)
    else $error("result with zero match count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (req_valid_i && ready_o) |=> state_q == S_RUN && step_q == '0)
    else $error("divider did not start on request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_RUN |-> step_q <= StpW'(DW - 1))
    else $error("divider step count overran");

endmodule

// ===== design/color_blob_centroid.sv =====
`timescale 1ns / 1ps
// color_blob_centroid: top level with APB register file, classifier front end,
// queue, accumulator and serial divider. Depends on cbc_pkg, cbc_if and submodules.
//
//  channel  | dir | transaction
//  ---------+-----+-------------------------------------------------------
//  pix_in   | in  | one RGB pixel plus end_of_frame flag, raster order
//  cen_out  | out | centre_x, centre_y (8 fraction bits), pixel_count
//  apb      | in  | register write/read: frame_width, red/green/blue limits
//
// One pixel per cycle while the 4-entry queue has room; the classifier and the queue
// decouple pixel intake from the accumulator. A frame's result is computed in the
// bit-serial divider after its last pixel, while the next frame keeps streaming in.
// The next last pixel stalls in the queue until the previous result has been taken.
// Reset clears position, sums and control state and loads the register defaults;
// no result is emitted for a frame with no match.
module color_blob_centroid #(
  parameter int MAX_WIDTH     = cbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = cbc_pkg::DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = cbc_pkg::DEF_FRACTION_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pixel_if.sink                      pix_in,
  centroid_if.source                 cen_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbc_pkg::ADDR_W-1:0] paddr,
  input  logic [cbc_pkg::DATA_W-1:0] pwdata,
  output logic [cbc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import cbc_pkg::*;

  localparam int EntW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2;

  logic [FW_W-1:0]  frame_width_q;
  logic [LIM_W-1:0] red_limit_q, green_limit_q, blue_limit_q;
  logic             wr_en;

  logic             full, push, pop, q_valid;
  logic [EntW-1:0]  push_entry, pop_entry;
  logic             div_ready, req_valid;
  div_req_t         req;

  // ---------------- register file ----------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= RST_FRAME_WIDTH;
      red_limit_q   <= RST_RED_LIMIT;
      green_limit_q <= RST_GREEN_LIMIT;
      blue_limit_q  <= RST_BLUE_LIMIT;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_FRAME_WIDTH: frame_width_q <= pwdata[FW_W-1:0];
        REG_RED_LIMIT:   red_limit_q   <= pwdata[LIM_W-1:0];
        REG_GREEN_LIMIT: green_limit_q <= pwdata[LIM_W-1:0];
        REG_BLUE_LIMIT:  blue_limit_q  <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH: prdata = DATA_W'(frame_width_q);
      REG_RED_LIMIT:   prdata = DATA_W'(red_limit_q);
      REG_GREEN_LIMIT: prdata = DATA_W'(green_limit_q);
      REG_BLUE_LIMIT:  prdata = DATA_W'(blue_limit_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  cbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_in        (pix_in),
    .frame_width_i (frame_width_q),
    .red_limit_i   (red_limit_q),
    .green_limit_i (green_limit_q),
    .blue_limit_i  (blue_limit_q),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  cbc_fifo #(
    .WIDTH (EntW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_entry)
  );

  cbc_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .div_ready_i (div_ready),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  cbc_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .ready_o     (div_ready),
    .cen_out     (cen_out)
  );

endmodule

// ===== dv/tb_color_blob_centroid.sv =====
`timescale 1ns / 1ps
// tb_color_blob_centroid: self-checking testbench for the color blob centroid block.
// Streams pixel frames, writes registers over APB and checks every centroid
// transaction against an in-bench predictor. Depends on cbc_pkg, cbc_if and the RTL.
module tb_color_blob_centroid;
  import cbc_pkg::*;

  localparam int              MAX_W        = DEF_MAX_WIDTH;
  localparam int              MAX_H        = DEF_MAX_HEIGHT;
  localparam int              FRAC         = DEF_FRACTION_BITS;
  localparam longint unsigned SUM_MAX      = (64'd1 << SUM_W) - 1;
  localparam longint unsigned COUNT_MAX    = (64'd1 << CNT_W) - 1;
  localparam longint unsigned CENTRE_MAX   = (64'd1 << CTR_W) - 1;
  localparam int              DRAIN_CYCLES = 100;
  localparam int              CYCLE_LIMIT  = 2000000;
  localparam int              RANDOM_ITEMS = 320;

  typedef struct packed {
    logic [CTR_W-1:0] centre_x;
    logic [CTR_W-1:0] centre_y;
    logic [CNT_W-1:0] pixel_count;
  } centroid_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pixel_if    pix ();
  centroid_if cen ();

  color_blob_centroid DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix),
    .cen_out (cen),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and the frame state
  logic [FW_W-1:0]  cfg_frame_width;
  logic [LIM_W-1:0] cfg_red_limit;
  logic [LIM_W-1:0] cfg_green_limit;
  logic [LIM_W-1:0] cfg_blue_limit;
  int unsigned      pos_column;
  int unsigned      pos_row;
  longint unsigned  sum_columns;
  longint unsigned  sum_rows;
  longint unsigned  match_count;
  centroid_t        expected_centroids[$];

  int error_count;
  int cycle_count;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result sink: a long hold-off when requested, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      cen.ready       <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      cen.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin : check_centroids
    centroid_t want;
    if (rst_ni && cen.valid && cen.ready) begin
      if (expected_centroids.size() == 0) begin
        report_mismatch($sformatf("unexpected centroid x=%0d y=%0d count=%0d",
                                  cen.centre_x, cen.centre_y, cen.pixel_count));
      end else begin
        want = expected_centroids.pop_front();
        if (cen.centre_x !== want.centre_x)
          report_mismatch($sformatf("centre_x got %0d want %0d", cen.centre_x,
                                    want.centre_x));
        if (cen.centre_y !== want.centre_y)
          report_mismatch($sformatf("centre_y got %0d want %0d", cen.centre_y,
                                    want.centre_y));
        if (cen.pixel_count !== want.pixel_count)
          report_mismatch($sformatf("pixel_count got %0d want %0d", cen.pixel_count,
                                    want.pixel_count));
      end
    end
  end

  function automatic longint unsigned sat_add(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned lim);
    longint unsigned s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  function automatic longint unsigned centre_of(input longint unsigned sum,
                                                input longint unsigned count);
    longint unsigned q;
    q = (sum << FRAC) / count;
    return (q > CENTRE_MAX) ? CENTRE_MAX : q;
  endfunction

  // Advance the centroid predictor by one accepted pixel
  function automatic void predict_pixel(input logic [LIM_W-1:0] r, input logic [LIM_W-1:0] g,
                                        input logic [LIM_W-1:0] b, input logic eof);
    int unsigned eff_width;
    centroid_t   result;
    eff_width = 32'(cfg_frame_width);
    if (eff_width == 0) eff_width = 1;
    if (eff_width > MAX_W) eff_width = MAX_W;
    if (r < cfg_red_limit && g > cfg_green_limit && b < cfg_blue_limit) begin
      sum_columns = sat_add(sum_columns, 64'(pos_column), SUM_MAX);
      sum_rows    = sat_add(sum_rows, 64'(pos_row), SUM_MAX);
      match_count = sat_add(match_count, 64'd1, COUNT_MAX);
    end
    if (eof) begin
      if (match_count > 0) begin
        result.centre_x    = CTR_W'(centre_of(sum_columns, match_count));
        result.centre_y    = CTR_W'(centre_of(sum_rows, match_count));
        result.pixel_count = CNT_W'(match_count);
        expected_centroids.push_back(result);
      end
      pos_column  = 0;
      pos_row     = 0;
      sum_columns = 0;
      sum_rows    = 0;
      match_count = 0;
    end else if (pos_column + 1 >= eff_width) begin
      pos_column = 0;
      if (pos_row + 1 < MAX_H) pos_row++;
    end else begin
      pos_column++;
    end
  endfunction

  // Matching pixels drawn from inside the limits, some right at the limits, rest noise
  function automatic void make_pixel(input int match_pct, output logic [LIM_W-1:0] r,
                                     output logic [LIM_W-1:0] g, output logic [LIM_W-1:0] b);
    if ($urandom_range(99) < match_pct) begin
      r = (cfg_red_limit == 0) ? LIM_W'($urandom) : LIM_W'($urandom_range(0, cfg_red_limit - 1));
      g = (cfg_green_limit == 8'hFF) ? LIM_W'($urandom)
                                     : LIM_W'($urandom_range(cfg_green_limit + 1, 255));
      b = (cfg_blue_limit == 0) ? LIM_W'($urandom) : LIM_W'($urandom_range(0, cfg_blue_limit - 1));
    end else if ($urandom_range(9) == 0) begin
      r = cfg_red_limit + LIM_W'($urandom_range(2)) - 8'd1;
      g = cfg_green_limit + LIM_W'($urandom_range(2)) - 8'd1;
      b = cfg_blue_limit + LIM_W'($urandom_range(2)) - 8'd1;
    end else begin
      r = LIM_W'($urandom);
      g = LIM_W'($urandom);
      b = LIM_W'($urandom);
    end
  endfunction

  // One pixel transaction; valid stays high afterwards so back-to-back items need no gap
  task automatic send_pixel(input logic [LIM_W-1:0] r, input logic [LIM_W-1:0] g,
                            input logic [LIM_W-1:0] b, input logic eof);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid        <= 1'b1;
    pix.red          <= r;
    pix.green        <= g;
    pix.blue         <= b;
    pix.end_of_frame <= eof;
    do @(posedge clk_i); while (!pix.ready);
    predict_pixel(r, g, b, eof);
  endtask

  // Stop sending, wait for all centroids, then let frames without a match drain
  task automatic wait_until_idle();
    pix.valid <= 1'b0;
    while (expected_centroids.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write followed by a readback; only called while the block is idle
  task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] stored;
    case (idx)
      REG_FRAME_WIDTH: begin
        cfg_frame_width = value[FW_W-1:0];
        stored = DATA_W'(cfg_frame_width);
      end
      REG_RED_LIMIT: begin
        cfg_red_limit = value[LIM_W-1:0];
        stored = DATA_W'(cfg_red_limit);
      end
      REG_GREEN_LIMIT: begin
        cfg_green_limit = value[LIM_W-1:0];
        stored = DATA_W'(cfg_green_limit);
      end
      default: begin
        cfg_blue_limit = value[LIM_W-1:0];
        stored = DATA_W'(cfg_blue_limit);
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== stored)
      report_mismatch($sformatf("register %0d reads %0h want %0h", idx, prdata, stored));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic randomize_config();
    logic [FW_W-1:0]  width;
    logic [LIM_W-1:0] red, green, blue;
    case ($urandom_range(9))
      0:       width = '0;
      1:       width = FW_W'(1);
      2:       width = FW_W'(MAX_W);
      3:       width = '1;
      4:       width = FW_W'($urandom_range(MAX_W + 1, 2047));
      5:       width = FW_W'($urandom_range(17, MAX_W - 1));
      default: width = FW_W'($urandom_range(2, 16));
    endcase
    case ($urandom_range(9))
      0:       red = 8'h00;
      1:       red = 8'hFF;
      default: red = LIM_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       green = 8'hFF;
      1:       green = 8'h00;
      default: green = LIM_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       blue = 8'h00;
      1:       blue = 8'hFF;
      default: blue = LIM_W'($urandom);
    endcase
    wait_until_idle();
    // upper bits carry noise; the register keeps only its own width
    write_register(REG_FRAME_WIDTH, DATA_W'({$urandom, width}));
    write_register(REG_RED_LIMIT, DATA_W'({$urandom, red}));
    write_register(REG_GREEN_LIMIT, DATA_W'({$urandom, green}));
    write_register(REG_BLUE_LIMIT, DATA_W'({$urandom, blue}));
  endtask

  // Strict comparisons at each limit, reset register values
  task automatic test_thresholds();
    send_pixel(8'd74, 8'd201, 8'd74, 1'b0);
    send_pixel(8'd75, 8'd201, 8'd74, 1'b0);
    send_pixel(8'd74, 8'd200, 8'd74, 1'b0);
    send_pixel(8'd74, 8'd201, 8'd75, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd74, 8'd201, 8'd74, 1'b1);
    wait_until_idle();
  endtask

  // No match gives no transaction; one-pixel frame; non-matching last pixel
  task automatic test_empty_frames();
    send_pixel(8'd200, 8'd10, 8'd200, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd10, 8'd250, 8'd10, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    wait_until_idle();
  endtask

  // Zero width acts as one; shrinking the width mid-frame below the column
  task automatic test_frame_width();
    write_register(REG_FRAME_WIDTH, 32'd0);
    send_pixel(8'd10, 8'd250, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd250, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd250, 8'd10, 1'b1);
    wait_until_idle();
    write_register(REG_FRAME_WIDTH, 32'd8);
    repeat (6) send_pixel(8'd10, 8'd250, 8'd10, 1'b0);
    wait_until_idle();
    write_register(REG_FRAME_WIDTH, 32'd4);
    send_pixel(8'd10, 8'd250, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd250, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd250, 8'd10, 1'b1);
    wait_until_idle();
  endtask

  task automatic test_limit_extremes();
    write_register(REG_RED_LIMIT, 32'd255);
    write_register(REG_GREEN_LIMIT, 32'd0);
    write_register(REG_BLUE_LIMIT, 32'd255);
    send_pixel(8'd254, 8'd1, 8'd254, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    wait_until_idle();
    write_register(REG_RED_LIMIT, 32'd0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    wait_until_idle();
  endtask

  // Width above the maximum saturates; then a zero width, acting as one, drives the row into saturation
  task automatic test_position_saturation();
    logic [LIM_W-1:0] r, g, b;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    write_register(REG_RED_LIMIT, 32'd128);
    write_register(REG_GREEN_LIMIT, 32'd127);
    write_register(REG_BLUE_LIMIT, 32'd128);
    write_register(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
    for (int i = 0; i < MAX_W + 6; i++) begin
      make_pixel(30, r, g, b);
      send_pixel(r, g, b, 1'b0);
    end
    wait_until_idle();
    write_register(REG_FRAME_WIDTH, 32'hFFFF_F800);
    for (int i = 0; i < MAX_H + 6; i++) begin
      make_pixel(30, r, g, b);
      send_pixel(r, g, b, i == MAX_H + 5);
    end
    wait_until_idle();
  endtask

  // Sink holds off for a long stretch while short frames keep arriving
  task automatic test_backpressure();
    logic [LIM_W-1:0] r, g, b;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    write_register(REG_FRAME_WIDTH, 32'd5);
    write_register(REG_RED_LIMIT, 32'd100);
    write_register(REG_GREEN_LIMIT, 32'd100);
    write_register(REG_BLUE_LIMIT, 32'd100);
    hold_off_cycles <= 400;
    for (int f = 0; f < 12; f++) begin
      for (int i = 0; i < 3; i++) begin
        make_pixel(100, r, g, b);
        send_pixel(r, g, b, i == 2);
      end
    end
    wait_until_idle();
  endtask

  task automatic test_random_frames();
    int               idle_table[4]  = '{0, 68, 0, 24};
    int               stall_table[4] = '{0, 0, 68, 24};
    int               sent;
    int               frame_len;
    int               match_pct;
    logic [LIM_W-1:0] r, g, b;
    for (int phase = 0; phase < 4; phase++) begin
      randomize_config();
      sender_idle_pct    = idle_table[phase];
      receiver_stall_pct = stall_table[phase];
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        if ($urandom_range(7) == 0) randomize_config();
        frame_len = ($urandom_range(15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        match_pct = ($urandom_range(9) == 0) ? 0 : $urandom_range(20, 90);
        for (int i = 0; i < frame_len; i++) begin
          make_pixel(match_pct, r, g, b);
          send_pixel(r, g, b, i == frame_len - 1);
        end
        sent += frame_len;
      end
    end
    wait_until_idle();
  endtask

  initial begin
    rst_ni             = 1'b0;
    pix.valid          = 1'b0;
    pix.red            = '0;
    pix.green          = '0;
    pix.blue           = '0;
    pix.end_of_frame   = 1'b0;
    cen.ready          = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    error_count        = 0;
    cycle_count        = 0;
    hold_off_cycles    = 0;
    sender_idle_pct    = 24;
    receiver_stall_pct = 24;
    cfg_frame_width    = RST_FRAME_WIDTH;
    cfg_red_limit      = RST_RED_LIMIT;
    cfg_green_limit    = RST_GREEN_LIMIT;
    cfg_blue_limit     = RST_BLUE_LIMIT;
    pos_column         = 0;
    pos_row            = 0;
    sum_columns        = 0;
    sum_rows           = 0;
    match_count        = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_thresholds();
    test_empty_frames();
    test_frame_width();
    test_limit_extremes();
    test_backpressure();
    test_position_saturation();
    test_random_frames();

    wait_until_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
